@@ src/otce_pkg.sv @@
package otce_pkg;

	// Fixed field widths of the input and result transactions.
	localparam int MODE_W    = 2;
	localparam int TRACK_W   = 10;
	localparam int GATE_W    = 13;
	localparam int CNT_W     = 11;

	// Track index widened so that it can be compared against any track count below 8192.
	localparam int TRK_EXT_W = 13;

	// One memory entry holds the remaining gate count and the opened mark.
	localparam int ENTRY_W   = GATE_W + 1;

	// Running counters saturate at their all-ones value.
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Result queue depth and the width of its occupancy count.
	localparam int QUEUE_DEPTH = 3;
	localparam int QCNT_W      = 2;
	localparam int QPTR_W      = 2;

	// Transaction codes carried in the mode field.
	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD    = 2'd0,
		MODE_TOUCH   = 2'd1,
		MODE_RESTART = 2'd2
	} mode_t;

	// One result transaction.
	typedef struct packed {
		logic [CNT_W-1:0] open_tracks;
		logic [CNT_W-1:0] max_open;
		logic             gate_done;
	} out_item_t;

endpackage

@@ src/otce_if.sv @@
// Input channel: one load, touch or restart transaction.
interface otce_in_if import otce_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [MODE_W-1:0]    mode;
	logic [TRACK_W-1:0]   track;
	logic [GATE_W-1:0]    gate_count;
	logic                 last_of_gate;

	modport source (output valid, output mode, output track, output gate_count,
		output last_of_gate, input ready);
	modport sink (input valid, input mode, input track, input gate_count,
		input last_of_gate, output ready);
endinterface

// Result channel: counts after each transaction.
interface otce_out_if import otce_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CNT_W-1:0]     open_tracks;
	logic [CNT_W-1:0]     max_open;
	logic                 gate_done;

	modport source (output valid, output open_tracks, output max_open,
		output gate_done, input ready);
	modport sink (input valid, input open_tracks, input max_open,
		input gate_done, output ready);
endinterface

@@ src/otce_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered data.
module otce_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read and a write to the same address in one cycle return the old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/otce_out_queue.sv @@
// Three-entry result queue that drives the result channel.
module otce_out_queue import otce_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  out_item_t         push_item,
	output logic [QCNT_W-1:0] count,
	otce_out_if.source        out_ch
);

	out_item_t         entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              pop;

	assign pop                = out_ch.valid && out_ch.ready;
	assign count              = count_q;
	assign out_ch.valid       = (count_q != '0);
	assign out_ch.open_tracks = entries_q[rd_ptr_q].open_tracks;
	assign out_ch.max_open    = entries_q[rd_ptr_q].max_open;
	assign out_ch.gate_done   = entries_q[rd_ptr_q].gate_done;

	// Payload storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers wrap at the queue depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ src/open_track_cost_evaluator.sv @@
// Result path: each accepted transaction is registered into stage 1, and its result is then
// pushed into the result queue, which offers it on the result channel. Throughput: one transaction per
// cycle while the result queue has room; each touch is a single read-modify-write of
// the track memory, with the previous write forwarded when it hits the same track.
// Reset: open, peak and pending-close counters clear at once; the track memory is
// not cleared, and a track's entry is defined only after its first load.
module open_track_cost_evaluator import otce_pkg::*; #(
	parameter int NUM_TRACKS = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	otce_in_if.sink    in_ch,
	otce_out_if.source out_ch
);

	localparam int AW = $clog2(NUM_TRACKS);

	// Saturating increment for the running counters.
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	logic                 in_fire;
	logic [TRK_EXT_W-1:0] trk_ext;
	logic [AW-1:0]        rd_addr;
	logic [ENTRY_W-1:0]   rd_data;

	logic                 valid_s1;
	logic [MODE_W-1:0]    mode_s1;
	logic [AW-1:0]        addr_s1;
	logic                 in_range_s1;
	logic [GATE_W-1:0]    gate_count_s1;
	logic                 last_s1;

	logic                 fwd_en_q;
	logic [AW-1:0]        fwd_addr_q;
	logic [ENTRY_W-1:0]   fwd_data_q;

	logic [CNT_W-1:0]     open_q;
	logic [CNT_W-1:0]     peak_q;
	logic [CNT_W-1:0]     pend_q;

	logic                 fwd_hit;
	logic [ENTRY_W-1:0]   entry;
	logic [GATE_W-1:0]    rem;
	logic                 opened;
	logic                 wr_en;
	logic [ENTRY_W-1:0]   wr_data;
	logic [CNT_W-1:0]     open_mid;
	logic [CNT_W-1:0]     pend_mid;
	logic [CNT_W-1:0]     open_d;
	logic [CNT_W-1:0]     peak_d;
	logic [CNT_W-1:0]     pend_d;
	logic                 done_d;
	out_item_t            result;
	logic [QCNT_W-1:0]    q_count;
	logic [QCNT_W:0]      occupancy;

	// Accept while the queue plus the item in flight leave room for one more.
	assign occupancy   = {1'b0, q_count} + {{QCNT_W{1'b0}}, valid_s1};
	assign in_ch.ready = (occupancy < (QCNT_W + 1)'(QUEUE_DEPTH));
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign trk_ext     = TRK_EXT_W'(in_ch.track);
	assign rd_addr     = trk_ext[AW-1:0];

	otce_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_TRACKS)
	) u_track_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata (wr_data),
		.re    (in_fire),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Stage 1 payload, captured alongside the memory read.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_s1       <= in_ch.mode;
			addr_s1       <= rd_addr;
			in_range_s1   <= (trk_ext < TRK_EXT_W'(NUM_TRACKS));
			gate_count_s1 <= in_ch.gate_count;
			last_s1       <= in_ch.last_of_gate;
		end
	end

	// The write of the previous cycle is not yet visible in the read data.
	assign fwd_hit = fwd_en_q && (fwd_addr_q == addr_s1);
	assign entry   = fwd_hit ? fwd_data_q : rd_data;
	assign rem     = entry[GATE_W-1:0];
	assign opened  = entry[GATE_W];

	// Track update and counter arithmetic for the item in stage 1.
	always_comb begin
		wr_en    = 1'b0;
		wr_data  = entry;
		open_mid = open_q;
		pend_mid = pend_q;
		open_d   = open_q;
		peak_d   = peak_q;
		pend_d   = pend_q;
		done_d   = 1'b0;
		if (valid_s1) begin
			unique case (mode_s1)
				MODE_LOAD: begin
					if (in_range_s1) begin
						wr_en   = 1'b1;
						wr_data = {1'b0, gate_count_s1};
					end
				end
				MODE_TOUCH: begin
					if (in_range_s1 && (rem != '0)) begin
						wr_en   = 1'b1;
						wr_data = {1'b1, rem - 1'b1};
						if (!opened) begin
							open_mid = sat_inc(open_q);
						end
						if (rem == GATE_W'(1)) begin
							pend_mid = sat_inc(pend_q);
						end
					end
					open_d = open_mid;
					pend_d = pend_mid;
					if (last_s1) begin
						peak_d = (open_mid > peak_q) ? open_mid : peak_q;
						open_d = (open_mid > pend_mid) ? open_mid - pend_mid : '0;
						pend_d = '0;
						done_d = 1'b1;
					end
				end
				MODE_RESTART: begin
					open_d = '0;
					peak_d = '0;
					pend_d = '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Forwarding register for the most recent track write.
	always_ff @(posedge clk) begin
		fwd_addr_q <= addr_s1;
		fwd_data_q <= wr_data;
	end

	// Control state and running counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_en_q <= 1'b0;
			open_q   <= '0;
			peak_q   <= '0;
			pend_q   <= '0;
		end else begin
			valid_s1 <= in_fire;
			fwd_en_q <= wr_en;
			open_q   <= open_d;
			peak_q   <= peak_d;
			pend_q   <= pend_d;
		end
	end

	assign result.open_tracks = open_d;
	assign result.max_open    = peak_d;
	assign result.gate_done   = done_d;

	otce_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_item (result),
		.count     (q_count),
		.out_ch    (out_ch)
	);

`ifndef SYNTHESIS
	// The result queue never receives an item while it is full, unless one leaves in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && (q_count == QCNT_W'(QUEUE_DEPTH)) && !(out_ch.valid && out_ch.ready)))
		else $error("result queue overflow");

	// Completing a gate leaves no pending closes and the open count within the peak.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (mode_s1 == MODE_TOUCH) && last_s1 |=>
			(pend_q == '0) && (open_q <= peak_q))
		else $error("gate completion left inconsistent counters");

	// A restart clears every running counter.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (mode_s1 == MODE_RESTART) |=>
			(open_q == '0) && (peak_q == '0) && (pend_q == '0))
		else $error("restart did not clear the counters");

	// A forwarded entry always comes from the item directly ahead.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && fwd_hit |-> $past(valid_s1))
		else $error("forwarding from a stale write");
`endif

endmodule
